/* hw/rtl/frame_playback_sequencer_assert.svh */
// ----------------------------------------------------------------------------
// frame playback sequencer assertion macros
// concurrent checks on a single clock with synchronous reset masking
// ----------------------------------------------------------------------------
`ifndef FRAME_PLAYBACK_SEQUENCER_ASSERT_SVH
`define FRAME_PLAYBACK_SEQUENCER_ASSERT_SVH

// consequent checked in the same cycle
`define FPS_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// consequent checked in the following cycle
`define FPS_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* hw/rtl/fps_pkg.sv */
// ----------------------------------------------------------------------------
// fps_pkg
// shared codes, field widths and control/status bundles of the sequencer
// ----------------------------------------------------------------------------
package fps_pkg;

   localparam int MODE_W   = 3;
   localparam int TOTAL_W  = 16;
   localparam int PERIOD_W = 32;
   localparam int OP_W     = 3;
   localparam int DELTA_W  = 20;
   localparam int SEEK_W   = 16;
   localparam int LOOP_W   = 16;
   localparam int OUTF_W   = 16;
   localparam int CSR_AW   = 2;
   localparam int REQ_W    = 40;
   localparam int RSP_W    = 24;

   localparam logic [OP_W-1:0] OP_UPDATE    = 3'd0;
   localparam logic [OP_W-1:0] OP_PLAY      = 3'd1;
   localparam logic [OP_W-1:0] OP_PAUSE     = 3'd2;
   localparam logic [OP_W-1:0] OP_RESET_POS = 3'd3;
   localparam logic [OP_W-1:0] OP_SEEK      = 3'd4;

   localparam logic [MODE_W-1:0] MODE_STOP        = 3'd0;
   localparam logic [MODE_W-1:0] MODE_ONCE        = 3'd1;
   localparam logic [MODE_W-1:0] MODE_REVERT_ONCE = 3'd2;
   localparam logic [MODE_W-1:0] MODE_LOOP        = 3'd3;
   localparam logic [MODE_W-1:0] MODE_REVERT_LOOP = 3'd4;
   localparam logic [MODE_W-1:0] MODE_PING_PONG   = 3'd5;

   localparam logic [CSR_AW-1:0] CSR_PLAY_MODE    = 2'd0;
   localparam logic [CSR_AW-1:0] CSR_FRAME_TOTAL  = 2'd1;
   localparam logic [CSR_AW-1:0] CSR_FRAME_PERIOD = 2'd2;

   localparam logic [MODE_W-1:0]   RST_PLAY_MODE    = MODE_LOOP;
   localparam logic [TOTAL_W-1:0]  RST_FRAME_TOTAL  = 16'd0;
   localparam logic [PERIOD_W-1:0] RST_FRAME_PERIOD = 32'd33333;

   typedef struct packed {
      logic load;
      logic simple;
      logic acc_add;
      logic steps_one;
      logic div_period;
      logic take_period;
      logic calc_f;
      logic div_loop;
      logic bump;
      logic clamp;
      logic div_mod;
      logic take_mod;
      logic apply;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic do_update;
      logic period_zero;
      logic steps_zero;
      logic wrap;
      logic need_mod;
      logic div_done;
      logic div_busy;
      logic slot_free;
   } stat_type;

endpackage

/* hw/rtl/fps_div.sv */
// ----------------------------------------------------------------------------
// fps_div
// radix-2 restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module fps_div #(
   parameter int DIVIDEND_W = 33,
   parameter int DIVISOR_W  = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [DIVIDEND_W-1:0] dividend,
   input  logic [DIVISOR_W-1:0]  divisor,
   output logic                  busy,
   output logic                  done,
   output logic [DIVIDEND_W-1:0] quotient,
   output logic [DIVISOR_W-1:0]  remainder
);

   localparam int CW = $clog2(DIVIDEND_W + 1);

   logic [DIVIDEND_W-1:0] quo_ff, quo_in;
   logic [DIVISOR_W-1:0]  rem_ff, rem_in;
   logic [DIVISOR_W-1:0]  dvs_ff, dvs_in;
   logic [CW-1:0]         cnt_ff, cnt_in;
   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [DIVISOR_W:0]    trial;
   logic [DIVISOR_W:0]    diff;
   logic                  ge;

   assign trial = {rem_ff, quo_ff[DIVIDEND_W-1]};
   assign ge    = trial >= {1'b0, dvs_ff};
   assign diff  = trial - {1'b0, dvs_ff};

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
         cnt_in  = CW'(DIVIDEND_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = ge ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
         quo_in = {quo_ff[DIVIDEND_W-2:0], ge};
         cnt_in = cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign busy      = busy_ff;
   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

/* hw/rtl/fps_ctrl.sv */
// ----------------------------------------------------------------------------
// fps_ctrl
// sequencing state machine: issues datapath commands for one beat at a time
// ----------------------------------------------------------------------------
module fps_ctrl import fps_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_tvalid,
   output logic     req_tready,
   input  stat_type stat,
   output cmd_type  cmd
);

   localparam logic [3:0] S_IDLE     = 4'd0;
   localparam logic [3:0] S_DISPATCH = 4'd1;
   localparam logic [3:0] S_PERIOD   = 4'd2;
   localparam logic [3:0] S_DIVP     = 4'd3;
   localparam logic [3:0] S_ADV      = 4'd4;
   localparam logic [3:0] S_WRAP     = 4'd5;
   localparam logic [3:0] S_DIVL     = 4'd6;
   localparam logic [3:0] S_DIVM     = 4'd7;
   localparam logic [3:0] S_FIN      = 4'd8;
   localparam logic [3:0] S_DONE     = 4'd9;

   logic [3:0] state_ff, state_in;

   assign req_tready = state_ff == S_IDLE;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            if (stat.do_update) begin
               cmd.acc_add = 1'b1;
               state_in    = S_PERIOD;
            end else begin
               cmd.simple = 1'b1;
               state_in   = S_DONE;
            end
         end
         S_PERIOD: begin
            if (stat.period_zero) begin
               cmd.steps_one = 1'b1;
               state_in      = S_ADV;
            end else begin
               cmd.div_period = 1'b1;
               state_in       = S_DIVP;
            end
         end
         S_DIVP: begin
            if (stat.div_done) begin
               cmd.take_period = 1'b1;
               state_in        = S_ADV;
            end
         end
         S_ADV: begin
            if (stat.steps_zero) begin
               state_in = S_DONE;
            end else begin
               cmd.calc_f = 1'b1;
               state_in   = S_WRAP;
            end
         end
         S_WRAP: begin
            if (stat.wrap) begin
               cmd.div_loop = 1'b1;
               state_in     = S_DIVL;
            end else begin
               state_in = S_FIN;
            end
         end
         S_DIVL: begin
            if (stat.div_done) begin
               cmd.bump = 1'b1;
               if (stat.need_mod) begin
                  cmd.div_mod = 1'b1;
                  state_in    = S_DIVM;
               end else begin
                  cmd.clamp = 1'b1;
                  state_in  = S_FIN;
               end
            end
         end
         S_DIVM: begin
            if (stat.div_done) begin
               cmd.take_mod = 1'b1;
               state_in     = S_FIN;
            end
         end
         S_FIN: begin
            cmd.apply = 1'b1;
            state_in  = S_DONE;
         end
         S_DONE: begin
            if (stat.slot_free) begin
               cmd.emit = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

/* hw/rtl/fps_dp.sv */
// ----------------------------------------------------------------------------
// fps_dp
// playback state, configuration registers, frame arithmetic and result slot
// ----------------------------------------------------------------------------
module fps_dp import fps_pkg::*; #(
   parameter int FRAME_BITS = 16,
   parameter int TIME_BITS  = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  cmd_type           cmd,
   output stat_type          stat,
   input  logic              csr_wr_en,
   input  logic [CSR_AW-1:0] csr_addr,
   input  logic [31:0]       csr_wdata,
   input  logic [REQ_W-1:0]  req_tdata,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [RSP_W-1:0]  rsp_tdata
);

   localparam int DW   = ((TIME_BITS > FRAME_BITS) ? TIME_BITS : FRAME_BITS) + 1;
   localparam int IW   = DW + 1;
   localparam int SUMW = ((TIME_BITS > DELTA_W) ? TIME_BITS : DELTA_W) + 1;
   localparam int CMPW = (FRAME_BITS > TOTAL_W) ? FRAME_BITS : TOTAL_W;

   logic [MODE_W-1:0]     mode_ff, mode_in;
   logic [TOTAL_W-1:0]    total_ff, total_in;
   logic [PERIOD_W-1:0]   period_ff, period_in;
   logic [OP_W-1:0]       op_ff, op_in;
   logic [DELTA_W-1:0]    delta_ff, delta_in;
   logic [SEEK_W-1:0]     seek_ff, seek_in;
   logic [FRAME_BITS-1:0] cur_ff, cur_in;
   logic [LOOP_W-1:0]     loop_ff, loop_in;
   logic [TIME_BITS-1:0]  acc_ff, acc_in;
   logic                  play_ff, play_in;
   logic [TIME_BITS-1:0]  steps_ff, steps_in;
   logic [DW-1:0]         fval_ff, fval_in;
   logic                  fwd_ff, fwd_in;
   logic                  wrap_ff, wrap_in;
   logic                  changed_ff, changed_in;
   logic                  rejected_ff, rejected_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RSP_W-1:0]      rsp_data_ff, rsp_data_in;

   logic                  div_start;
   logic [DW-1:0]         div_dividend;
   logic [PERIOD_W-1:0]   div_divisor;
   logic                  div_busy;
   logic                  div_done;
   logic [DW-1:0]         div_quo;
   logic [PERIOD_W-1:0]   div_rem;

   logic [SUMW-1:0]       acc_sum;
   logic [TIME_BITS-1:0]  acc_sat;
   logic [TOTAL_W-1:0]    last;
   logic [TOTAL_W-1:0]    reset_frame;
   logic                  fwd_now;
   logic                  active_mode;
   logic [DW-1:0]         cur_w;
   logic [DW-1:0]         steps_w;
   logic [DW-1:0]         fwd_sum;
   logic [IW-1:0]         loop_inc;
   logic [IW-1:0]         loop_room;
   logic                  fval_fits;
   logic [FRAME_BITS-1:0] cur_next;
   logic                  stop_now;
   logic                  at_end;

   fps_div #(
      .DIVIDEND_W(DW),
      .DIVISOR_W (PERIOD_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .busy     (div_busy),
      .done     (div_done),
      .quotient (div_quo),
      .remainder(div_rem)
   );

   assign div_start    = cmd.div_period | cmd.div_loop | cmd.div_mod;
   assign div_dividend = cmd.div_period ? DW'(acc_ff) : fval_ff;
   assign div_divisor  = cmd.div_period ? period_ff :
                         cmd.div_loop   ? PERIOD_W'(total_ff) + PERIOD_W'(1) :
                                          PERIOD_W'(total_ff);

   assign acc_sum     = SUMW'(acc_ff) + SUMW'(delta_ff);
   assign acc_sat     = (acc_sum > SUMW'({TIME_BITS{1'b1}})) ? {TIME_BITS{1'b1}} :
                        TIME_BITS'(acc_sum);
   assign last        = total_ff - TOTAL_W'(1);
   assign reset_frame = ((mode_ff == MODE_REVERT_ONCE) || (mode_ff == MODE_REVERT_LOOP)) ?
                        ((total_ff == '0) ? '0 : last) : '0;
   assign fwd_now     = (mode_ff == MODE_ONCE) || (mode_ff == MODE_LOOP) ||
                        ((mode_ff == MODE_PING_PONG) && !loop_ff[0]);
   assign active_mode = (mode_ff >= MODE_ONCE) && (mode_ff <= MODE_PING_PONG);
   assign cur_w       = DW'(cur_ff);
   assign steps_w     = DW'(steps_ff);
   assign fwd_sum     = cur_w + steps_w;
   assign loop_inc    = IW'(div_quo) + IW'(1);
   assign loop_room   = IW'(LOOP_W'('1) - loop_ff);
   assign fval_fits   = fval_ff < DW'(total_ff);
   assign cur_next    = fval_fits ? FRAME_BITS'(fval_ff) : cur_ff;
   assign stop_now    = ((mode_ff == MODE_ONCE) && (CMPW'(cur_next) == CMPW'(last))) ||
                        ((mode_ff == MODE_REVERT_ONCE) && (cur_next == '0));
   assign at_end      = (mode_ff == MODE_ONCE) ?
                        ((total_ff != '0) && (CMPW'(cur_ff) >= CMPW'(last))) :
                        (mode_ff == MODE_REVERT_ONCE) ? (cur_ff == '0) : 1'b0;

   assign stat.do_update   = (op_ff == OP_UPDATE) && (total_ff >= TOTAL_W'(2)) &&
                             play_ff && active_mode;
   assign stat.period_zero = period_ff == '0;
   assign stat.steps_zero  = steps_ff == '0;
   assign stat.wrap        = wrap_ff;
   assign stat.need_mod    = fwd_ff ? (mode_ff == MODE_LOOP) : (mode_ff == MODE_REVERT_LOOP);
   assign stat.div_done    = div_done;
   assign stat.div_busy    = div_busy;
   assign stat.slot_free   = !rsp_valid_ff || rsp_tready;

   always_comb begin
      mode_in      = mode_ff;
      total_in     = total_ff;
      period_in    = period_ff;
      op_in        = op_ff;
      delta_in     = delta_ff;
      seek_in      = seek_ff;
      cur_in       = cur_ff;
      loop_in      = loop_ff;
      acc_in       = acc_ff;
      play_in      = play_ff;
      steps_in     = steps_ff;
      fval_in      = fval_ff;
      fwd_in       = fwd_ff;
      wrap_in      = wrap_ff;
      changed_in   = changed_ff;
      rejected_in  = rejected_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;

      if (csr_wr_en) begin
         case (csr_addr)
            CSR_PLAY_MODE:    mode_in   = csr_wdata[MODE_W-1:0];
            CSR_FRAME_TOTAL:  total_in  = csr_wdata[TOTAL_W-1:0];
            CSR_FRAME_PERIOD: period_in = csr_wdata[PERIOD_W-1:0];
            default: ;
         endcase
      end

      if (cmd.load) begin
         op_in       = req_tdata[OP_W-1:0];
         delta_in    = req_tdata[OP_W +: DELTA_W];
         seek_in     = req_tdata[OP_W+DELTA_W +: SEEK_W];
         changed_in  = 1'b0;
         rejected_in = 1'b0;
      end

      if (cmd.simple) begin
         case (op_ff)
            OP_PLAY: begin
               if (!play_ff) begin
                  play_in = 1'b1;
                  loop_in = '0;
                  acc_in  = '0;
               end
            end
            OP_PAUSE: begin
               if (play_ff) begin
                  play_in = 1'b0;
                  loop_in = '0;
                  acc_in  = '0;
               end
            end
            OP_RESET_POS: begin
               loop_in = '0;
               acc_in  = '0;
               if (reset_frame < total_ff) begin
                  cur_in     = FRAME_BITS'(reset_frame);
                  changed_in = 1'b1;
               end else begin
                  rejected_in = 1'b1;
               end
            end
            OP_SEEK: begin
               if (seek_ff < total_ff) begin
                  cur_in     = FRAME_BITS'(seek_ff);
                  changed_in = 1'b1;
               end else begin
                  rejected_in = 1'b1;
               end
            end
            default: ;
         endcase
      end

      if (cmd.acc_add) begin
         acc_in = acc_sat;
      end

      if (cmd.steps_one) begin
         steps_in = TIME_BITS'(1);
      end

      if (cmd.take_period) begin
         acc_in   = TIME_BITS'(div_rem);
         steps_in = TIME_BITS'(div_quo);
      end

      if (cmd.calc_f) begin
         fwd_in = fwd_now;
         if (fwd_now) begin
            fval_in = fwd_sum;
            wrap_in = fwd_sum >= DW'(last);
         end else if (steps_w >= cur_w) begin
            // backward to or past frame zero: keep the overshoot magnitude
            fval_in = steps_w - cur_w;
            wrap_in = 1'b1;
         end else begin
            fval_in = cur_w - steps_w;
            wrap_in = 1'b0;
         end
      end

      if (cmd.bump) begin
         loop_in = (loop_inc >= loop_room) ? LOOP_W'('1) : loop_ff + LOOP_W'(loop_inc);
      end

      if (cmd.clamp) begin
         fval_in = fwd_ff ? DW'(last) : '0;
      end

      if (cmd.take_mod) begin
         if (fwd_ff) begin
            fval_in = DW'(div_rem);
         end else begin
            fval_in = (div_rem == '0) ? '0 : DW'(total_ff - TOTAL_W'(div_rem));
         end
      end

      if (cmd.apply) begin
         cur_in     = cur_next;
         changed_in = fval_fits;
         if (stop_now) begin
            play_in = 1'b0;
            loop_in = '0;
            acc_in  = '0;
         end
      end

      if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {4'b0000, rejected_ff, changed_ff, at_end, play_ff, OUTF_W'(cur_ff)};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= RST_PLAY_MODE;
         total_ff     <= RST_FRAME_TOTAL;
         period_ff    <= RST_FRAME_PERIOD;
         cur_ff       <= '0;
         loop_ff      <= '0;
         acc_ff       <= '0;
         play_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         mode_ff      <= mode_in;
         total_ff     <= total_in;
         period_ff    <= period_in;
         cur_ff       <= cur_in;
         loop_ff      <= loop_in;
         acc_ff       <= acc_in;
         play_ff      <= play_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff       <= op_in;
      delta_ff    <= delta_in;
      seek_ff     <= seek_in;
      steps_ff    <= steps_in;
      fval_ff     <= fval_in;
      fwd_ff      <= fwd_in;
      wrap_ff     <= wrap_in;
      changed_ff  <= changed_in;
      rejected_ff <= rejected_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

/* hw/rtl/frame_playback_sequencer.sv */
// ----------------------------------------------------------------------------
// frame_playback_sequencer
// animation frame sequencer: time updates, play/pause, reset position, seek
// ----------------------------------------------------------------------------
// usage
//   req_ channel carries one command beat (op, delta_time, seek_frame); every
//   beat yields exactly one rsp_ beat with the frame index and status flags.
//   csr_ port writes play_mode, frame_total and frame_period; user must do so only while idle (unchecked).
//   one beat is processed at a time; req_tready is high only between beats.
//   play, pause, reset position and seek: dispatch, then done, which loads
//   the result register. time update: paced by the shared one-bit-per-cycle
//   divider, used for the period split, the loop count and the wrap modulo;
//   with no wrap only the period split runs.
//   the result sits in an output register, so a new beat is accepted while
//   the previous result waits; a stalled receiver only holds the next result.
//   reset clears frame, loop count, time accumulator and playing flag, and
//   loads the register defaults (loop mode, no frames, 33333 ticks).
// ----------------------------------------------------------------------------
`include "frame_playback_sequencer_assert.svh"

module frame_playback_sequencer import fps_pkg::*; #(
   parameter int FRAME_BITS = 16,
   parameter int TIME_BITS  = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [REQ_W-1:0]  req_tdata,   // op, delta_time, seek_frame
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [RSP_W-1:0]  rsp_tdata,   // frame_now, is_playing, at_end,
                                          // frame_changed, seek_rejected
   input  logic              csr_wr_en,
   input  logic [CSR_AW-1:0] csr_addr,
   input  logic [31:0]       csr_wdata
);

   cmd_type  cmd;
   stat_type stat;

   fps_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .stat      (stat),
      .cmd       (cmd)
   );

   fps_dp #(
      .FRAME_BITS(FRAME_BITS),
      .TIME_BITS (TIME_BITS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .stat      (stat),
      .csr_wr_en (csr_wr_en),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .req_tdata (req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata)
   );

   `FPS_ASSERT_NEXT(a_one_in_flight, clock, reset, req_tvalid && req_tready, !req_tready, "beat accepted while another is in progress")
   `FPS_ASSERT_SAME(a_no_overwrite, clock, reset, cmd.emit, !rsp_tvalid || rsp_tready, "pending result overwritten")
   `FPS_ASSERT_SAME(a_div_idle, clock, reset, cmd.div_period || cmd.div_loop || cmd.div_mod, !stat.div_busy, "divider restarted while busy")

endmodule

/* tb/sv/frame_playback_checker.sv */
// ----------------------------------------------------------------------------
// frame_playback_checker
// watches the csr port and both stream channels of the frame sequencer,
// predicts the status beat of every accepted command beat from its own copy
// of the playback state, and compares result beats field by field in order
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module frame_playback_checker import fps_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   input  logic              req_tready,
   input  logic [REQ_W-1:0]  req_tdata,   // op, delta_time, seek_frame
   input  logic              rsp_tvalid,
   input  logic              rsp_tready,
   input  logic [RSP_W-1:0]  rsp_tdata,   // frame_now, is_playing, at_end,
                                          // frame_changed, seek_rejected
   input  logic              csr_wr_en,
   input  logic [CSR_AW-1:0] csr_addr,
   input  logic [31:0]       csr_wdata,
   output int                fail_count,
   output int                results_seen,
   output int                pending
);

   typedef struct {
      logic [OUTF_W-1:0] frame_now;
      logic              is_playing;
      logic              at_end;
      logic              frame_changed;
      logic              seek_rejected;
   } frame_status_t;

   localparam int REPORT_CAP = 200;

   frame_status_t status_queue[$];
   int            reports = 0;

   logic [MODE_W-1:0]   mode_cfg;
   logic [TOTAL_W-1:0]  total_cfg;
   logic [PERIOD_W-1:0] period_cfg;

   logic [OUTF_W-1:0]   frame_pos;
   logic [LOOP_W-1:0]   loop_tally;
   logic [31:0]         tick_accum;
   logic                running;

   function automatic void set_running(input logic p);
      if (running != p) begin
         running    = p;
         loop_tally = '0;
         tick_accum = '0;
      end
   endfunction

   function automatic void add_loops(input longint inc);
      if (inc >= 65535 - longint'(loop_tally))
         loop_tally = '1;
      else
         loop_tally = loop_tally + 16'(inc);
   endfunction

   function automatic void step_frames(input longint steps, output logic changed);
      longint tot;
      longint last;
      longint f;
      logic   fwd;
      changed = 1'b0;
      tot  = longint'(total_cfg);
      last = tot - 1;
      f    = longint'(frame_pos);
      fwd  = mode_cfg == MODE_ONCE || mode_cfg == MODE_LOOP ||
             (mode_cfg == MODE_PING_PONG && !loop_tally[0]);
      if (fwd) begin
         f = f + steps;
         if (f >= last) begin
            add_loops(1 + f / (tot + 1));
            f = (mode_cfg == MODE_LOOP) ? f % tot : last;
         end
      end else begin
         f = f - steps;
         if (f <= 0) begin
            add_loops(1 + (-f) / (tot + 1));
            // true modulo, also when tot + f is still negative
            f = (mode_cfg == MODE_REVERT_LOOP) ? (((tot + f) % tot) + tot) % tot : 0;
         end
      end
      if (f < tot) begin
         frame_pos = 16'(f);
         changed   = 1'b1;
      end
      if ((mode_cfg == MODE_ONCE && longint'(frame_pos) == last) ||
          (mode_cfg == MODE_REVERT_ONCE && frame_pos == '0))
         set_running(1'b0);
   endfunction

   function automatic frame_status_t predict_status(input logic [OP_W-1:0] op,
                                                    input logic [DELTA_W-1:0] delta,
                                                    input logic [SEEK_W-1:0] target);
      frame_status_t     s;
      longint unsigned   sum;
      longint unsigned   steps;
      logic              changed;
      logic              rejected;
      logic [TOTAL_W-1:0] dest;
      changed  = 1'b0;
      rejected = 1'b0;
      case (op)
         OP_UPDATE: begin
            if (total_cfg >= 2 && running && mode_cfg >= MODE_ONCE &&
                mode_cfg <= MODE_PING_PONG) begin
               sum = longint'(tick_accum) + longint'(delta);
               if (sum > 64'hFFFF_FFFF)
                  tick_accum = '1;
               else
                  tick_accum = sum[31:0];
               if (period_cfg == '0) begin
                  steps = 1;
               end else begin
                  steps      = tick_accum / period_cfg;
                  tick_accum = tick_accum % period_cfg;
               end
               if (steps != 0)
                  step_frames(longint'(steps), changed);
            end
         end
         OP_PLAY:  set_running(1'b1);
         OP_PAUSE: set_running(1'b0);
         OP_RESET_POS: begin
            dest = '0;
            if (mode_cfg == MODE_REVERT_ONCE || mode_cfg == MODE_REVERT_LOOP)
               dest = (total_cfg == '0) ? '0 : total_cfg - 16'd1;
            tick_accum = '0;
            loop_tally = '0;
            if (dest < total_cfg) begin
               frame_pos = dest;
               changed   = 1'b1;
            end else begin
               rejected = 1'b1;
            end
         end
         OP_SEEK: begin
            if (target < total_cfg) begin
               frame_pos = target;
               changed   = 1'b1;
            end else begin
               rejected = 1'b1;
            end
         end
         default: ;
      endcase
      s.frame_now     = frame_pos;
      s.is_playing    = running;
      s.frame_changed = changed;
      s.seek_rejected = rejected;
      if (mode_cfg == MODE_ONCE)
         s.at_end = total_cfg >= 1 && frame_pos >= total_cfg - 1;
      else if (mode_cfg == MODE_REVERT_ONCE)
         s.at_end = frame_pos == '0;
      else
         s.at_end = 1'b0;
      return s;
   endfunction

   task automatic check_field(input string field, input longint want, input longint got,
                              inout logic bad);
      if (want != got) begin
         bad = 1'b1;
         if (reports < REPORT_CAP)
            $error("%s: expected %0d, actual %0d", field, want, got);
         reports++;
      end
   endtask

   always @(posedge clock) begin
      frame_status_t want;
      logic          bad;
      if (reset) begin
         mode_cfg     = RST_PLAY_MODE;
         total_cfg    = RST_FRAME_TOTAL;
         period_cfg   = RST_FRAME_PERIOD;
         frame_pos    = '0;
         loop_tally   = '0;
         tick_accum   = '0;
         running      = 1'b0;
         fail_count   = 0;
         results_seen = 0;
         status_queue.delete();
      end else begin
         if (csr_wr_en) begin
            case (csr_addr)
               CSR_PLAY_MODE:    mode_cfg   = csr_wdata[MODE_W-1:0];
               CSR_FRAME_TOTAL:  total_cfg  = csr_wdata[TOTAL_W-1:0];
               CSR_FRAME_PERIOD: period_cfg = csr_wdata[PERIOD_W-1:0];
               default: ;
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            results_seen++;
            if (status_queue.size() == 0) begin
               fail_count++;
               if (reports < REPORT_CAP)
                  $error("unexpected result beat, frame_now %0d", rsp_tdata[15:0]);
               reports++;
            end else begin
               want = status_queue.pop_front();
               bad  = 1'b0;
               check_field("frame_now", want.frame_now, rsp_tdata[15:0], bad);
               check_field("is_playing", want.is_playing, rsp_tdata[16], bad);
               check_field("at_end", want.at_end, rsp_tdata[17], bad);
               check_field("frame_changed", want.frame_changed, rsp_tdata[18], bad);
               check_field("seek_rejected", want.seek_rejected, rsp_tdata[19], bad);
               if (bad)
                  fail_count++;
            end
         end
         if (req_tvalid && req_tready)
            status_queue.push_back(predict_status(req_tdata[2:0], req_tdata[22:3],
                                                  req_tdata[38:23]));
      end
      pending = status_queue.size();
   end

endmodule

/* tb/sv/tb.sv */
// ----------------------------------------------------------------------------
// tb
// drives the frame sequencer with directed command beats, a long run that
// saturates the time accumulator, and random playback phases under random
// csr settings, with bursty senders and a stalling receiver; the checker
// beside the block predicts and compares every status beat
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;
   import fps_pkg::*;

   localparam logic [OP_W-1:0]     OP_SPARE_5    = 3'd5;
   localparam logic [OP_W-1:0]     OP_SPARE_6    = 3'd6;
   localparam logic [OP_W-1:0]     OP_SPARE_7    = 3'd7;
   localparam logic [MODE_W-1:0]   MODE_SPARE_6  = 3'd6;
   localparam logic [MODE_W-1:0]   MODE_SPARE_7  = 3'd7;
   localparam logic [DELTA_W-1:0]  DELTA_MAX     = '1;
   localparam logic [SEEK_W-1:0]   SEEK_MAX      = '1;
   localparam logic [TOTAL_W-1:0]  TOTAL_MAX     = '1;
   localparam logic [PERIOD_W-1:0] PERIOD_MAX    = '1;
   localparam int                  RANDOM_BEATS  = 2000;
   localparam int                  SATURATE_RUNS = 4200;

   logic              clock      = 1'b0;
   logic              reset      = 1'b1;
   logic              req_tvalid = 1'b0;
   logic              req_tready;
   logic [REQ_W-1:0]  req_tdata  = '0;   // op, delta_time, seek_frame
   logic              rsp_tvalid;
   logic              rsp_tready = 1'b0;
   logic [RSP_W-1:0]  rsp_tdata;         // frame_now, is_playing, at_end,
                                         // frame_changed, seek_rejected
   logic              csr_wr_en  = 1'b0;
   logic [CSR_AW-1:0] csr_addr   = '0;
   logic [31:0]       csr_wdata  = '0;

   int fail_count;
   int results_seen;
   int pending;

   int beats_sent  = 0;
   int burst_left  = 0;
   int gap_max     = 2;
   int stall_left  = 0;
   int stall_kind  = 0;
   int stall_tick  = 0;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   frame_playback_sequencer dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wr_en  (csr_wr_en),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   frame_playback_checker status_checker (
      .clock        (clock),
      .reset        (reset),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_tdata    (req_tdata),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata),
      .csr_wr_en    (csr_wr_en),
      .csr_addr     (csr_addr),
      .csr_wdata    (csr_wdata),
      .fail_count   (fail_count),
      .results_seen (results_seen),
      .pending      (pending)
   );

   // receiver stall pattern
   always @(negedge clock) begin
      if (stall_left == 0) begin
         stall_kind = $urandom_range(0, 3);
         stall_left = $urandom_range(20, 200);
      end
      stall_left--;
      stall_tick++;
      case (stall_kind)
         0:       rsp_tready <= 1'b1;
         1:       rsp_tready <= ($urandom_range(0, 3) != 0);
         2:       rsp_tready <= ((stall_tick % 7) < 3);
         default: rsp_tready <= ($urandom_range(0, 9) == 0);
      endcase
   end

   task automatic drive_beat(input logic [OP_W-1:0] op, input logic [DELTA_W-1:0] delta,
                             input logic [SEEK_W-1:0] target);
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(0, gap_max);
         repeat (gap) begin
            @(negedge clock);
            req_tvalid <= 1'b0;
         end
         burst_left = $urandom_range(1, 12);
      end
      burst_left--;
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= {1'b0, target, delta, op};
      do @(posedge clock); while (!req_tready);
      beats_sent++;
   endtask

   task automatic settle();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending != 0)
         @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_AW-1:0] addr, input logic [31:0] value);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_addr  <= addr;
      csr_wdata <= value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic configure(input logic [MODE_W-1:0] mode, input logic [TOTAL_W-1:0] total,
                            input logic [PERIOD_W-1:0] period);
      settle();
      write_reg(CSR_PLAY_MODE, 32'(mode));
      write_reg(CSR_FRAME_TOTAL, 32'(total));
      write_reg(CSR_FRAME_PERIOD, period);
   endtask

   function automatic logic [MODE_W-1:0] pick_mode();
      int r;
      r = $urandom_range(0, 19);
      if (r == 0)
         return MODE_STOP;
      else if (r == 1)
         return $urandom_range(MODE_SPARE_6, MODE_SPARE_7);
      return $urandom_range(MODE_ONCE, MODE_PING_PONG);
   endfunction

   function automatic logic [TOTAL_W-1:0] pick_total();
      int r;
      r = $urandom_range(0, 9);
      case (r)
         0:       return '0;
         1:       return 16'd1;
         2:       return 16'd2;
         3, 4:    return $urandom_range(3, 16);
         5, 6:    return $urandom_range(17, 300);
         7:       return $urandom_range(0, TOTAL_MAX);
         8:       return TOTAL_MAX;
         default: return $urandom_range(300, 5000);
      endcase
   endfunction

   function automatic logic [PERIOD_W-1:0] pick_period();
      int r;
      r = $urandom_range(0, 9);
      case (r)
         0:       return '0;
         1, 2:    return $urandom_range(1, 16);
         3, 4:    return $urandom_range(17, 5000);
         5:       return $urandom_range(5001, DELTA_MAX);
         6:       return $urandom;
         7:       return PERIOD_MAX;
         8:       return RST_FRAME_PERIOD;
         default: return $urandom_range(1, 100);
      endcase
   endfunction

   function automatic logic [DELTA_W-1:0] pick_delta(input logic [PERIOD_W-1:0] period);
      int r;
      r = $urandom_range(0, 9);
      if (r == 0)
         return '0;
      else if (r == 1)
         return DELTA_MAX;
      else if (r < 4 || period == '0 || period > 262143)
         return $urandom_range(0, DELTA_MAX);
      return $urandom_range(0, 4 * period);
   endfunction

   function automatic logic [SEEK_W-1:0] pick_seek(input logic [TOTAL_W-1:0] total);
      if (total != '0 && $urandom_range(0, 1) == 1)
         return $urandom_range(0, total - 1);
      return $urandom_range(0, SEEK_MAX);
   endfunction

   initial begin
      logic [MODE_W-1:0]   mode;
      logic [TOTAL_W-1:0]  total;
      logic [PERIOD_W-1:0] period;
      int                  random_sent;
      int                  n;
      int                  r;
      logic                tidy;
      random_sent = 0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // register defaults: no trajectory, so nothing moves and frame writes fail
      drive_beat(OP_UPDATE, DELTA_MAX, '0);
      drive_beat(OP_SEEK, '0, '0);
      drive_beat(OP_RESET_POS, '0, SEEK_MAX);

      // once mode at the largest trajectory, stops on the last frame
      configure(MODE_ONCE, TOTAL_MAX, '0);
      drive_beat(OP_SEEK, '0, SEEK_MAX);
      drive_beat(OP_SEEK, '0, SEEK_MAX - 16'd1);
      drive_beat(OP_PLAY, '0, '0);
      drive_beat(OP_UPDATE, '0, '0);

      // revert once, huge step count drives the loop counter into saturation
      configure(MODE_REVERT_ONCE, 16'd3, 32'd1);
      drive_beat(OP_RESET_POS, '0, '0);
      drive_beat(OP_PLAY, '0, '0);
      drive_beat(OP_UPDATE, DELTA_MAX, '0);

      // revert loop wraps backward, including a modulo of a negative value
      configure(MODE_REVERT_LOOP, 16'd7, 32'd3);
      drive_beat(OP_PLAY, '0, '0);
      drive_beat(OP_UPDATE, 20'd20, '0);
      drive_beat(OP_UPDATE, 20'd1, '0);
      drive_beat(OP_UPDATE, 20'd60, '0);

      // ping pong turns around at both ends
      configure(MODE_PING_PONG, 16'd2, '0);
      repeat (3) drive_beat(OP_UPDATE, '0, '0);

      // unknown mode and unknown ops, repeated pause
      configure(MODE_SPARE_7, 16'd9, 32'd5);
      drive_beat(OP_UPDATE, 20'd100, '0);
      drive_beat(OP_SPARE_5, DELTA_MAX, SEEK_MAX);
      drive_beat(OP_SPARE_6, '0, '0);
      drive_beat(OP_SPARE_7, DELTA_MAX, SEEK_MAX);
      drive_beat(OP_PAUSE, '0, '0);
      drive_beat(OP_PAUSE, '0, '0);

      // longest period, then the accumulator saturates with a zero period
      configure(MODE_LOOP, TOTAL_MAX, PERIOD_MAX);
      drive_beat(OP_PLAY, '0, '0);
      drive_beat(OP_UPDATE, DELTA_MAX, '0);
      configure(MODE_LOOP, 16'd3, '0);
      gap_max = 0;
      drive_beat(OP_PAUSE, '0, '0);
      drive_beat(OP_PLAY, '0, '0);
      repeat (SATURATE_RUNS) drive_beat(OP_UPDATE, DELTA_MAX, '0);
      settle();
      write_reg(CSR_FRAME_PERIOD, 32'd1000);
      drive_beat(OP_UPDATE, '0, '0);
      drive_beat(OP_UPDATE, DELTA_MAX, '0);

      // random playback phases
      while (random_sent < RANDOM_BEATS) begin
         mode   = pick_mode();
         total  = pick_total();
         period = pick_period();
         configure(mode, total, period);
         gap_max = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         n       = $urandom_range(40, 120);
         tidy    = $urandom_range(0, 99) < 85;
         if (tidy) begin
            if ($urandom_range(0, 2) == 0)
               drive_beat(OP_RESET_POS, pick_delta('0), pick_seek('0));
            drive_beat(OP_PLAY, pick_delta('0), pick_seek('0));
         end
         repeat (n) begin
            r = $urandom_range(0, 99);
            if (!tidy)
               drive_beat($urandom_range(0, OP_SPARE_7), pick_delta('0), pick_seek('0));
            else if (r < 70)
               drive_beat(OP_UPDATE, pick_delta(period), pick_seek('0));
            else if (r < 78)
               drive_beat(OP_PLAY, pick_delta('0), pick_seek('0));
            else if (r < 83)
               drive_beat(OP_PAUSE, pick_delta('0), pick_seek('0));
            else if (r < 88)
               drive_beat(OP_RESET_POS, pick_delta('0), pick_seek('0));
            else if (r < 96)
               drive_beat(OP_SEEK, pick_delta('0), pick_seek(total));
            else
               drive_beat($urandom_range(OP_SPARE_5, OP_SPARE_7), pick_delta('0),
                          pick_seek('0));
         end
         random_sent += n;
      end

      settle();
      repeat (150) @(negedge clock);
      $display("tb: %0d command beats driven, %0d status beats checked",
               beats_sent, results_seen);
      $display("tb: all modes and ops, accumulator and loop counter saturation, random csr");
      if (fail_count == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

   initial begin
      #20_000_000;
      $display("tb: failure");
      $finish;
   end

endmodule
